@@ hw/rtl/sle_pkg.sv @@
`timescale 1ns / 1ps

package sle_pkg;

  // Operation codes on the input word
  localparam logic [1:0] FN_SORT   = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;

  // Status codes on the output word
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FOUND    = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } sle_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } sle_out_t;

  // What a token does as it walks the cells
  typedef enum logic [1:0] {
    K_NONE,
    K_SORT,
    K_APPEND,
    K_SEARCH
  } tok_kind_t;

  typedef struct packed {
    logic       valid;
    tok_kind_t  kind;
    logic       placed;
    logic [1:0] status;
  } tok_ctl_t;

endpackage

@@ hw/rtl/sorted_list_engine.sv @@
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values, built as a chain of
// CAPACITY cells; cell i holds list entry i. An accepted word becomes a token
// that walks the chain one cell per cycle while not stalled: a sorted
// insert or append drops its value into the first cell that qualifies and
// ripples the displaced entries one cell down, a search marks the first
// equal cell. A new word is accepted every cycle unless the output is
// stalled; a result leaves once its token crosses all CAPACITY cells, and
// results come out in order. Every later token sees each cell only after all
// earlier tokens have passed it, so operations take effect in arrival order.
// The entry count is kept at the head of the chain and updated on accept,
// which is where a full list is detected and rejected. A stall on the output
// holds the whole chain. The list is empty after reset; no clearing pass.
// position and entry_count report the low 4 and 5 bits.
module sorted_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sle_pkg::sle_in_t  in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output sle_pkg::sle_out_t out_word
);
  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Token links: index i feeds cell i, index CAPACITY is the chain output
  tok_ctl_t           ctl       [0:CAPACITY];
  logic signed [31:0] val       [0:CAPACITY];
  logic [CW-1:0]      cnt_before[0:CAPACITY];
  logic [CW-1:0]      cnt_after [0:CAPACITY];
  logic [IW-1:0]      pos       [0:CAPACITY];
  logic signed [31:0] carry     [0:CAPACITY];

  logic          advance;
  logic          accept;
  logic          full;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [31:0]   pos_ext;
  logic [31:0]   cnt_ext;

  // Advance the whole chain unless the output word is stalled
  assign advance  = !ctl[CAPACITY].valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(CAPACITY));

  // Build the head token; full-list and unused codes pass through as no-ops
  always_comb begin
    ctl[0].valid  = accept;
    ctl[0].placed = 1'b0;
    ctl[0].kind   = K_NONE;
    ctl[0].status = ST_MISSING;
    count_next    = count;
    case (in_word.func)
      FN_SORT, FN_APPEND: begin
        if (full) begin
          ctl[0].status = ST_FULL;
        end else begin
          ctl[0].kind   = (in_word.func == FN_SORT) ? K_SORT : K_APPEND;
          ctl[0].status = ST_INSERTED;
          count_next    = count + CW'(1);
        end
      end
      FN_SEARCH: begin
        ctl[0].kind = K_SEARCH;
      end
      default: begin
        ctl[0].kind = K_NONE;
      end
    endcase
  end

  assign val[0]        = in_word.value;
  assign cnt_before[0] = count;
  assign cnt_after[0]  = count_next;
  assign pos[0]        = '0;
  assign carry[0]      = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sle_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .advance        (advance),
      .prev_ctl       (ctl[i]),
      .prev_value     (val[i]),
      .prev_cnt_before(cnt_before[i]),
      .prev_cnt_after (cnt_after[i]),
      .prev_pos       (pos[i]),
      .prev_carry     (carry[i]),
      .tok_ctl        (ctl[i+1]),
      .tok_value      (val[i+1]),
      .tok_cnt_before (cnt_before[i+1]),
      .tok_cnt_after  (cnt_after[i+1]),
      .tok_pos        (pos[i+1]),
      .tok_carry      (carry[i+1])
    );
  end

  // Drop the last cell's token onto the output word, masked to field widths
  assign pos_ext = 32'(pos[CAPACITY]);
  assign cnt_ext = 32'(cnt_after[CAPACITY]);

  assign out_valid            = ctl[CAPACITY].valid;
  assign out_word.status      = ctl[CAPACITY].status;
  assign out_word.position    = pos_ext[3:0];
  assign out_word.entry_count = cnt_ext[4:0];

endmodule

@@ hw/rtl/sle_cell.sv @@
`timescale 1ns / 1ps

module sle_cell #(
  parameter int CAPACITY = 16,
  parameter int INDEX = 0,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  sle_pkg::tok_ctl_t  prev_ctl,
  input  logic signed [31:0] prev_value,
  input  logic [CW-1:0]      prev_cnt_before,
  input  logic [CW-1:0]      prev_cnt_after,
  input  logic [IW-1:0]      prev_pos,
  input  logic signed [31:0] prev_carry,
  output sle_pkg::tok_ctl_t  tok_ctl,
  output logic signed [31:0] tok_value,
  output logic [CW-1:0]      tok_cnt_before,
  output logic [CW-1:0]      tok_cnt_after,
  output logic [IW-1:0]      tok_pos,
  output logic signed [31:0] tok_carry
);
  import sle_pkg::*;

  localparam bit FIRST = (INDEX == 0);

  logic signed [31:0] entry;
  logic signed [31:0] entry_next;
  logic signed [31:0] carry_next;
  logic [IW-1:0]      pos_next;
  tok_ctl_t           ctl_next;
  logic               occ;
  logic               hit;
  logic               is_ins;
  logic               place;
  logic               shift;
  logic               found;

  assign occ    = prev_cnt_before > CW'(INDEX);
  assign is_ins = (prev_ctl.kind == K_SORT) || (prev_ctl.kind == K_APPEND);

  always_comb begin
    case (prev_ctl.kind)
      K_SORT:   hit = !occ || (FIRST ? (prev_value < entry) : !(entry < prev_value));
      K_APPEND: hit = !occ;
      default:  hit = 1'b0;
    endcase
  end

  assign place = prev_ctl.valid && !prev_ctl.placed && is_ins && hit;
  assign shift = prev_ctl.valid && prev_ctl.placed && is_ins;
  assign found = prev_ctl.valid && !prev_ctl.placed && (prev_ctl.kind == K_SEARCH)
                 && occ && (entry == prev_value);

  // Insert here, or take the displaced word and pass ours on
  always_comb begin
    entry_next = entry;
    carry_next = prev_carry;
    pos_next   = prev_pos;
    ctl_next   = prev_ctl;
    if (place) begin
      entry_next = prev_value;
      carry_next = entry;
    end else if (shift) begin
      entry_next = prev_carry;
      carry_next = entry;
    end
    if (place || found) begin
      ctl_next.placed = 1'b1;
      pos_next        = IW'(INDEX);
    end
    if (found) begin
      ctl_next.status = ST_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry          <= entry_next;
      tok_value      <= prev_value;
      tok_cnt_before <= prev_cnt_before;
      tok_cnt_after  <= prev_cnt_after;
      tok_pos        <= pos_next;
      tok_carry      <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_ctl <= '0;
    end else if (advance) begin
      tok_ctl <= ctl_next;
    end
  end

endmodule

@@ hw/rtl/sle_checker.sv @@
`timescale 1ns / 1ps

module sle_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input sle_pkg::sle_in_t  in_word,
  input logic              out_valid,
  input logic              out_ready,
  input sle_pkg::sle_out_t out_word
);
  import sle_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // Rejections and misses report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_FULL || out_word.status == ST_MISSING)
    |-> out_word.position == 4'd0)
    else $error("nonzero position on reject or miss");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 31) || (32'(out_word.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  // A hit or insert lies inside the held entries
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_INSERTED || out_word.status == ST_FOUND)
    |-> (CAPACITY > 15) || (out_word.position < out_word.entry_count))
    else $error("position outside held entries");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);

@@ sim/sorted_list_engine_tb.sv @@
`timescale 1ns / 1ps

module sorted_list_engine_tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH = 16;
  // The spare selector value: the block changes nothing and reports not found
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1800;
  localparam int DRAIN_CYCLES = 3 * LIST_DEPTH;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    sle_in_t  word;
    bit       typed;
    sle_out_t res;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  sle_in_t  in_word;
  logic     out_valid;
  logic     out_ready;
  sle_out_t out_word;

  // Shadow copy of the list as the predictor sees it
  logic signed [31:0] held_vals [LIST_DEPTH];
  int                 held_count;

  // Results still owed by the block, oldest first
  sle_out_t  pending_results [$];
  sle_out_t  next_res;
  sle_out_t  want_res;
  int        err_count;

  // Expected result carried along with the word on the bus, for table rows
  // whose result is written out by hand
  bit        cur_typed;
  sle_out_t  cur_typed_res;

  stim_row_t dir_rows [$];
  int        burst_left;

  sorted_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Apply one operation to the shadow list and return what the block owes.
  function automatic sle_out_t apply_list_op(input sle_in_t w);
    sle_out_t           r;
    int                 slot;
    int                 i;
    logic signed [31:0] v;
    v = $signed(w.value);
    r.status = ST_MISSING;
    slot = 0;
    if (w.func == FN_SORT || w.func == FN_APPEND) begin
      if (held_count >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (w.func == FN_APPEND) begin
          slot = held_count;
        end else if (held_count == 0 || v < held_vals[0]) begin
          slot = 0;
        end else begin
          // Entry 0 is skipped: a value equal to it lands after it
          slot = held_count;
          for (i = 1; i < held_count; i++) begin
            if (!(held_vals[i] < v)) begin
              slot = i;
              break;
            end
          end
        end
        for (i = held_count; i > slot; i--) begin
          held_vals[i] = held_vals[i - 1];
        end
        held_vals[slot] = v;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else if (w.func == FN_SEARCH) begin
      for (i = 0; i < held_count; i++) begin
        if (held_vals[i] == v) begin
          r.status = ST_FOUND;
          slot = i;
          break;
        end
      end
    end
    if (r.status == ST_FULL || r.status == ST_MISSING) begin
      slot = 0;
    end
    r.position = slot[3:0];
    r.entry_count = held_count[4:0];
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic [1:0] f, input logic [31:0] v);
    stim_row_t r;
    r.word.func = f;
    r.word.value = v;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t fix_row(input logic [1:0] f, input logic [31:0] v,
                                        input logic [1:0] st, input logic [3:0] pos,
                                        input logic [4:0] cnt);
    stim_row_t r;
    r = chk_row(f, v);
    r.typed = 1'b1;
    r.res.status = st;
    r.res.position = pos;
    r.res.entry_count = cnt;
    return r;
  endfunction

  // Random word, mostly searches aimed at held values and their neighbors
  function automatic sle_in_t pick_word();
    sle_in_t w;
    int      pick;
    int      sel;
    pick = $urandom_range(0, 99);
    if (pick < 55) w.func = FN_SEARCH;
    else if (pick < 72) w.func = FN_SORT;
    else if (pick < 88) w.func = FN_APPEND;
    else w.func = FN_UNUSED;
    sel = $urandom_range(0, 9);
    if (sel <= 3 && held_count > 0) begin
      w.value = held_vals[$urandom_range(0, held_count - 1)];
    end else if (sel == 4 && held_count > 0) begin
      w.value = held_vals[$urandom_range(0, held_count - 1)];
      w.value = $urandom_range(0, 1) ? w.value + 1 : w.value - 1;
    end else if (sel == 5) begin
      case ($urandom_range(0, 3))
        0:       w.value = 32'h8000_0000;
        1:       w.value = 32'h7fff_ffff;
        2:       w.value = 32'h0000_0000;
        default: w.value = 32'hffff_ffff;
      endcase
    end else begin
      w.value = $urandom;
    end
    return w;
  endfunction

  // Present one word and hold it until the block takes it; the sender runs
  // in bursts with idle gaps in between.
  task automatic send_word(input sle_in_t w, input bit typed, input sle_out_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    cur_typed <= typed;
    cur_typed_res <= res;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: switch between stall patterns at random intervals
  initial begin
    int mode;
    int left;
    int phase;
    out_ready = 1'b0;
    left = 0;
    phase = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      phase++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (phase % 4) == 0;
        default: out_ready <= (phase % 13) < 9 ? 1'b0 : 1'b1;
      endcase
    end
  end

  // Predict on every accepted word, check every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        next_res = apply_list_op(in_word);
        if (cur_typed) begin
          next_res = cur_typed_res;
        end
        pending_results.push_back(next_res);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d position=%0d count=%0d",
                                  out_word.status, out_word.position,
                                  out_word.entry_count));
        end else begin
          want_res = pending_results.pop_front();
          if (out_word.status !== want_res.status) begin
            flag_mismatch($sformatf("status %0d, want %0d",
                                    out_word.status, want_res.status));
          end
          if (out_word.position !== want_res.position) begin
            flag_mismatch($sformatf("position %0d, want %0d",
                                    out_word.position, want_res.position));
          end
          if (out_word.entry_count !== want_res.entry_count) begin
            flag_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_word.entry_count, want_res.entry_count));
          end
        end
      end
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cur_typed = 1'b0;
    cur_typed_res = '0;
    held_count = 0;
    err_count = 0;
    burst_left = 0;

    // Empty list: search and the spare selector both miss
    dir_rows.push_back(fix_row(FN_SEARCH, 32'd5, ST_MISSING, 4'd0, 5'd0));
    dir_rows.push_back(fix_row(FN_UNUSED, 32'd5, ST_MISSING, 4'd0, 5'd0));
    dir_rows.push_back(fix_row(FN_SORT, 32'd100, ST_INSERTED, 4'd0, 5'd1));
    // Equal to the head: goes after it
    dir_rows.push_back(chk_row(FN_SORT, 32'd100));
    dir_rows.push_back(chk_row(FN_SORT, 32'h8000_0000));
    dir_rows.push_back(chk_row(FN_SORT, 32'h7fff_ffff));
    dir_rows.push_back(chk_row(FN_SORT, 32'd100));
    dir_rows.push_back(chk_row(FN_APPEND, 32'hffff_fffb));
    dir_rows.push_back(chk_row(FN_SORT, 32'd0));
    dir_rows.push_back(chk_row(FN_SORT, 32'd200));
    dir_rows.push_back(chk_row(FN_SEARCH, 32'd100));
    // Last held entry must be found
    dir_rows.push_back(chk_row(FN_SEARCH, 32'hffff_fffb));
    dir_rows.push_back(chk_row(FN_SEARCH, 32'h8000_0000));
    dir_rows.push_back(chk_row(FN_SEARCH, 32'd7));
    dir_rows.push_back(chk_row(FN_SORT, 32'h8000_0000));
    dir_rows.push_back(chk_row(FN_APPEND, 32'h5555_5555));
    dir_rows.push_back(chk_row(FN_SORT, 32'hffff_ffff));
    dir_rows.push_back(chk_row(FN_APPEND, 32'haaaa_aaaa));
    dir_rows.push_back(chk_row(FN_SORT, 32'd50));
    dir_rows.push_back(chk_row(FN_SORT, 32'd1));
    dir_rows.push_back(chk_row(FN_APPEND, 32'd0));
    dir_rows.push_back(chk_row(FN_SORT, 32'd7));
    // Sixteen held: both kinds of insert are turned away
    dir_rows.push_back(fix_row(FN_SORT, 32'd3, ST_FULL, 4'd0, 5'd16));
    dir_rows.push_back(fix_row(FN_APPEND, 32'd3, ST_FULL, 4'd0, 5'd16));
    dir_rows.push_back(fix_row(FN_UNUSED, 32'd3, ST_MISSING, 4'd0, 5'd16));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].res);
    end
    for (n = 0; n < RANDOM_WORDS; n++) begin
      send_word(pick_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then give the chain time to show any stray result
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
